/* rtl/lpfs_pkg.sv */
// shared constants and types for the length-prefixed frame splitter
`default_nettype none
package lpfs_pkg;

   localparam int unsigned HDR_BYTES           = 16;
   localparam int unsigned STORE_BYTES         = HDR_BYTES - 1;
   localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;
   localparam int unsigned SIZE_W              = 9;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [31:0]       sender;
      logic [31:0]       code;
      logic [31:0]       msg_type;
      logic [SIZE_W-1:0] payload_size;
      logic              size_error;
      logic [7:0]        payload_byte;
      logic              last_byte;
   } result_type;

endpackage
`default_nettype wire

/* rtl/length_prefixed_frame_splitter.sv */
// top level of the length-prefixed frame splitter
//
// req channel: one stream byte per word (req_data_byte), valid/stall handshake.
// rsp channel: one result word per header or payload byte, valid/stall.
// a message is a 16-byte header of four little-endian words (sender, code,
// type, size) followed by size payload bytes. the sixteenth header byte
// yields a header word; every payload byte yields a payload word, the
// final one marked with rsp_last_byte. an empty payload or a size that is
// negative or above MAX_PAYLOAD marks last on the header word itself; a bad
// size also sets rsp_size_error and the next byte starts a new header.
// the result register puts a result on rsp in the cycle after its byte is accepted.
// throughput: one byte per cycle; the parser and the result register form
// one stage, so a byte is taken whenever the result register is empty or
// is being read in the same cycle.
// when the receiver stalls with a word held, req_stall rises and the
// stream holds until the word is taken. reset empties the result register
// and returns the parser to header collection.
`default_nettype none
module length_prefixed_frame_splitter #(
   parameter int unsigned MAX_PAYLOAD = lpfs_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_data_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_kind,
   output logic [31:0]                      rsp_sender,
   output logic [31:0]                      rsp_code,
   output logic [31:0]                      rsp_msg_type,
   output logic [lpfs_pkg::SIZE_W-1:0]      rsp_payload_size,
   output logic                             rsp_size_error,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_last_byte
);

   logic                 ready;
   logic                 take;
   logic                 res_valid;
   lpfs_pkg::result_type res;
   lpfs_pkg::result_type rsp_data;

   assign req_stall = !ready;
   assign take      = req_valid && ready;

   lpfs_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take && res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ready     (ready)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_sender       = rsp_data.sender;
   assign rsp_code         = rsp_data.code;
   assign rsp_msg_type     = rsp_data.msg_type;
   assign rsp_payload_size = rsp_data.payload_size;
   assign rsp_size_error   = rsp_data.size_error;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_last_byte    = rsp_data.last_byte;

endmodule
`default_nettype wire

/* rtl/lpfs_parser.sv */
// header collection, size check and payload byte counting
`default_nettype none
module lpfs_parser #(
   parameter int unsigned MAX_PAYLOAD = lpfs_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [7:0]          data_byte,
   output logic                     res_valid,
   output lpfs_pkg::result_type     res
);

   localparam int unsigned BL_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned CNT_W = $clog2(lpfs_pkg::HDR_BYTES);
   localparam logic [31:0] LIMIT = 32'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lpfs_pkg::STORE_BYTES);

   logic                               in_payload_ff, in_payload_in;
   logic [CNT_W-1:0]                   header_count_ff, header_count_in;
   logic [BL_W-1:0]                    bytes_left_ff, bytes_left_in;
   logic [lpfs_pkg::STORE_BYTES-1:0][7:0] hdr_ff, hdr_in;

   logic [31:0] size_word;
   logic        size_err;
   logic        hdr_done;

   // the oldest header byte ends up at index 0 after fifteen shifts
   assign size_word = {data_byte, hdr_ff[14], hdr_ff[13], hdr_ff[12]};
   assign size_err  = size_word[31] || (size_word > LIMIT);
   assign hdr_done  = !in_payload_ff && (header_count_ff == CNT_LAST);

   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      bytes_left_in   = bytes_left_ff;
      hdr_in          = hdr_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (in_payload_ff) begin
         res_valid        = 1'b1;
         res.kind         = lpfs_pkg::KIND_PAYLOAD;
         res.payload_byte = data_byte;
         if (bytes_left_ff != '0) begin
            bytes_left_in = bytes_left_ff - BL_W'(1);
         end
         if (bytes_left_ff <= BL_W'(1)) begin
            res.last_byte = 1'b1;
            in_payload_in = 1'b0;
         end
      end else if (!hdr_done) begin
         hdr_in          = {data_byte, hdr_ff[lpfs_pkg::STORE_BYTES-1:1]};
         header_count_in = header_count_ff + CNT_W'(1);
      end else begin
         res_valid       = 1'b1;
         header_count_in = '0;
         res.kind        = lpfs_pkg::KIND_HEADER;
         res.sender      = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
         res.code        = {hdr_ff[7], hdr_ff[6], hdr_ff[5], hdr_ff[4]};
         res.msg_type    = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
         if (size_err) begin
            res.size_error = 1'b1;
            res.last_byte  = 1'b1;
            in_payload_in  = 1'b0;
            bytes_left_in  = '0;
         end else begin
            res.payload_size = size_word[lpfs_pkg::SIZE_W-1:0];
            if (size_word == 32'd0) begin
               res.last_byte = 1'b1;
               in_payload_in = 1'b0;
               bytes_left_in = '0;
            end else begin
               in_payload_in = 1'b1;
               bytes_left_in = size_word[BL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= '0;
         bytes_left_ff   <= '0;
      end else if (take) begin
         in_payload_ff   <= in_payload_in;
         header_count_ff <= header_count_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hdr_ff <= hdr_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/lpfs_out_reg.sv */
// result register between the parser and the result channel
`default_nettype none
module lpfs_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire lpfs_pkg::result_type res,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output lpfs_pkg::result_type      rsp_data,
   output logic                      ready
);

   logic                 valid_ff, valid_in;
   lpfs_pkg::result_type data_ff;

   // room when empty or when the held word leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire
